// ===== src/min_jerk_quintic_coefficients_assert.svh =====
// Assertion macros for the quintic coefficient block.
`ifndef MIN_JERK_QUINTIC_COEFFICIENTS_ASSERT_SVH
`define MIN_JERK_QUINTIC_COEFFICIENTS_ASSERT_SVH

// consequent in the cycle after the antecedent
`define MJQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// consequent in the same cycle as the antecedent
`define MJQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/mjq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the quintic coefficient block.
`default_nettype none
package mjq_pkg;

   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;
   localparam int NUM_W    = 100;
   localparam int DIV_W    = 192;
   localparam int CNT_W    = $clog2(DIV_W);

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_SEGMENT = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic        [31:0] duration;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]  axis;
      logic signed [63:0] coeff0;
      logic signed [63:0] coeff1;
      logic signed [63:0] coeff2;
      logic signed [63:0] coeff3;
      logic signed [63:0] coeff4;
      logic signed [63:0] coeff5;
      logic               bad_duration;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] coeff0;
      logic signed [63:0] coeff1;
      logic signed [63:0] coeff2;
      logic signed [63:0] coeff3;
      logic signed [63:0] coeff4;
      logic signed [63:0] coeff5;
      logic               bad;
   } lane_result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lane_status_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_LOAD,
      LANE_DIV,
      LANE_DONE
   } lane_state_type;

   typedef enum logic [2:0] {
      MS_VT,
      MS_AT1,
      MS_PLO,
      MS_PHI,
      MS_FORM
   } mul_step_type;

   typedef enum logic [1:0] {
      COEF_C3,
      COEF_C4,
      COEF_C5
   } coef_type;

   function automatic logic signed [NUM_W-1:0] numer(input coef_type c,
                                                      input logic signed [NUM_W-1:0] hs,
                                                      input logic signed [NUM_W-1:0] vs,
                                                      input logic signed [NUM_W-1:0] as);
      logic signed [NUM_W-1:0] r;
      r = '0;
      case (c)
         COEF_C3: r = (hs <<< 4) + (hs <<< 2) - (vs <<< 3) - (vs <<< 2) - (as <<< 1) - as;
         COEF_C4: r = (hs <<< 1) - (hs <<< 5) + (vs <<< 4) + (as <<< 1) + as;
         COEF_C5: r = (hs <<< 3) + (hs <<< 2) - (vs <<< 2) - (vs <<< 1) - as;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] coef_shift(input coef_type c);
      logic [6:0] r;
      r = 7'd0;
      case (c)
         COEF_C3: r = 7'd39;
         COEF_C4: r = 7'd63;
         COEF_C5: r = 7'd87;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] coef_power(input coef_type c);
      logic [2:0] r;
      r = 3'd1;
      case (c)
         COEF_C3: r = 3'd3;
         COEF_C4: r = 3'd4;
         COEF_C5: r = 3'd5;
         default: r = 3'd1;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] sat_coeff(input logic [DIV_W-1:0] q, input logic neg);
      logic        hi;
      logic [63:0] mag;
      logic [63:0] r;
      hi  = |q[DIV_W-1:64];
      mag = q[63:0];
      if (neg) begin
         if (hi || mag > {1'b1, 63'd0}) begin
            r = {1'b1, 63'd0};
         end else begin
            r = -mag;
         end
      end else begin
         if (hi || mag[63]) begin
            r = {1'b0, {63{1'b1}}};
         end else begin
            r = mag;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/mjq_lane.sv =====
// One axis lane: start state, product sequence and serial divider for c3..c5.
`default_nettype none
module mjq_lane import mjq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic               func,
   input  wire logic signed [31:0] pos,
   input  wire logic signed [31:0] vel,
   input  wire logic signed [31:0] acc,
   input  wire logic        [31:0] tq,
   input  wire logic               take,
   output lane_status_type         status,
   output lane_result_type         result
);

   lane_state_type          state_ff, state_in;
   mul_step_type            step_ff, step_in;
   coef_type                coef_ff, coef_in;
   logic signed [31:0]      p_ff, p_in, v_ff, v_in, a_ff, a_in;
   logic signed [31:0]      v0w_ff, v0w_in, a0w_ff, a0w_in;
   logic signed [32:0]      h_ff, h_in;
   logic        [31:0]      tq_ff, tq_in;
   logic        [63:0]      vt_ff, vt_in, at1_ff, at1_in, plo_ff, plo_in, phi_ff, phi_in;
   logic signed [NUM_W-1:0] hs_ff, hs_in, vts_ff, vts_in, ats_ff, ats_in;
   logic        [2:0]       pass_ff, pass_in;
   logic        [CNT_W-1:0] bit_ff, bit_in;
   logic        [DIV_W-1:0] x_ff, x_in;
   logic        [31:0]      rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   lane_result_type         res_ff, res_in;

   logic        [31:0]      mul_a, mul_b;
   logic        [63:0]      mul_p;
   logic        [31:0]      v_abs, a_abs;
   logic        [95:0]      at2_sum;
   logic signed [NUM_W-1:0] vt_mag, n_val;
   logic        [NUM_W-1:0] n_abs;
   logic        [32:0]      trial, diff;
   logic                    ge;
   logic        [DIV_W-1:0] x_next;
   logic        [63:0]      sat_val;

   assign v_abs   = v0w_ff[31] ? 32'(-v0w_ff) : 32'(v0w_ff);
   assign a_abs   = a0w_ff[31] ? 32'(-a0w_ff) : 32'(a0w_ff);
   assign mul_p   = mul_a * mul_b;
   assign at2_sum = {32'd0, plo_ff} + {phi_ff, 32'd0};
   assign vt_mag  = NUM_W'(signed'({(NUM_W-64)'(0), vt_ff}) <<< 24);
   assign n_val   = numer(coef_ff, hs_ff, vts_ff, ats_ff);
   assign n_abs   = n_val[NUM_W-1] ? NUM_W'(-n_val) : NUM_W'(n_val);
   assign trial   = {rem_ff, x_ff[DIV_W-1]};
   assign diff    = trial - {1'b0, tq_ff};
   assign ge      = trial >= {1'b0, tq_ff};
   assign x_next  = {x_ff[DIV_W-2:0], ge};
   assign sat_val = sat_coeff(x_next, neg_ff);

   always_comb begin
      mul_a = v_abs;
      mul_b = tq_ff;
      unique case (step_ff)
         MS_VT:   mul_a = v_abs;
         MS_AT1:  mul_a = a_abs;
         MS_PLO:  mul_a = at1_ff[31:0];
         MS_PHI:  mul_a = at1_ff[63:32];
         MS_FORM: mul_a = v_abs;
         default: mul_a = v_abs;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         step_ff  <= MS_VT;
         coef_ff  <= COEF_C3;
         p_ff     <= '0;
         v_ff     <= '0;
         a_ff     <= '0;
         pass_ff  <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         coef_ff  <= coef_in;
         p_ff     <= p_in;
         v_ff     <= v_in;
         a_ff     <= a_in;
         pass_ff  <= pass_in;
         bit_ff   <= bit_in;
      end
      v0w_ff <= v0w_in;
      a0w_ff <= a0w_in;
      h_ff   <= h_in;
      tq_ff  <= tq_in;
      vt_ff  <= vt_in;
      at1_ff <= at1_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      hs_ff  <= hs_in;
      vts_ff <= vts_in;
      ats_ff <= ats_in;
      x_ff   <= x_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      coef_in  = coef_ff;
      p_in     = p_ff;
      v_in     = v_ff;
      a_in     = a_ff;
      v0w_in   = v0w_ff;
      a0w_in   = a0w_ff;
      h_in     = h_ff;
      tq_in    = tq_ff;
      vt_in    = vt_ff;
      at1_in   = at1_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      hs_in    = hs_ff;
      vts_in   = vts_ff;
      ats_in   = ats_ff;
      pass_in  = pass_ff;
      bit_in   = bit_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      unique case (state_ff)
         LANE_IDLE: begin
            if (go && func == FUNC_START) begin
               p_in = pos;
               v_in = vel;
               a_in = acc;
            end else if (go) begin
               v0w_in = v_ff;
               a0w_in = a_ff;
               h_in   = {pos[31], pos} - {p_ff[31], p_ff};
               tq_in  = tq;
               p_in   = pos;
               v_in   = '0;
               a_in   = '0;
               res_in = '0;
               if (tq == 32'd0) begin
                  res_in.bad = 1'b1;
                  state_in   = LANE_DONE;
               end else begin
                  res_in.coeff0 = {{16{p_ff[31]}}, p_ff, 16'd0};
                  res_in.coeff1 = {{16{v_ff[31]}}, v_ff, 16'd0};
                  res_in.coeff2 = {{17{a_ff[31]}}, a_ff, 15'd0};
                  step_in       = MS_VT;
                  state_in      = LANE_MUL;
               end
            end
         end
         LANE_MUL: begin
            unique case (step_ff)
               MS_VT: begin
                  vt_in   = mul_p;
                  step_in = MS_AT1;
               end
               MS_AT1: begin
                  at1_in  = mul_p;
                  step_in = MS_PLO;
               end
               MS_PLO: begin
                  plo_in  = mul_p;
                  step_in = MS_PHI;
               end
               MS_PHI: begin
                  phi_in  = mul_p;
                  step_in = MS_FORM;
               end
               MS_FORM: begin
                  hs_in    = NUM_W'(h_ff) <<< 48;
                  vts_in   = v0w_ff[31] ? -vt_mag : vt_mag;
                  ats_in   = a0w_ff[31] ? -NUM_W'(signed'({4'd0, at2_sum}))
                                        : NUM_W'(signed'({4'd0, at2_sum}));
                  coef_in  = COEF_C3;
                  step_in  = MS_VT;
                  state_in = LANE_LOAD;
               end
               default: step_in = MS_VT;
            endcase
         end
         LANE_LOAD: begin
            neg_in   = n_val[NUM_W-1];
            x_in     = DIV_W'(n_abs) << coef_shift(coef_ff);
            pass_in  = coef_power(coef_ff);
            bit_in   = '0;
            rem_in   = '0;
            state_in = LANE_DIV;
         end
         LANE_DIV: begin
            x_in   = x_next;
            rem_in = ge ? diff[31:0] : trial[31:0];
            bit_in = bit_ff + CNT_W'(1);
            if (bit_ff == CNT_W'(DIV_W - 1)) begin
               bit_in  = '0;
               rem_in  = '0;
               pass_in = pass_ff - 3'd1;
               if (pass_ff == 3'd1) begin
                  unique case (coef_ff)
                     COEF_C3: begin
                        res_in.coeff3 = sat_val;
                        coef_in       = COEF_C4;
                        state_in      = LANE_LOAD;
                     end
                     COEF_C4: begin
                        res_in.coeff4 = sat_val;
                        coef_in       = COEF_C5;
                        state_in      = LANE_LOAD;
                     end
                     COEF_C5: begin
                        res_in.coeff5 = sat_val;
                        state_in      = LANE_DONE;
                     end
                     default: state_in = LANE_DONE;
                  endcase
               end
            end
         end
         LANE_DONE: begin
            if (take) begin
               state_in = LANE_IDLE;
            end
         end
         default: state_in = LANE_IDLE;
      endcase
   end

   assign status.idle = state_ff == LANE_IDLE;
   assign status.done = state_ff == LANE_DONE;
   assign result      = res_ff;

endmodule
`default_nettype wire

// ===== src/mjq_merge.sv =====
// Merge stage: gathers the lane results and sends them out one axis per word.
`default_nettype none
module mjq_merge import mjq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lane_status_type lane_status [NUM_AXES],
   input  wire lane_result_type lane_result [NUM_AXES],
   output logic                 take,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_word
);

   logic              full_ff, full_in;
   logic [AXIS_W-1:0] idx_ff, idx_in;
   lane_result_type   buf_ff [NUM_AXES];
   logic              all_done;
   logic              is_last;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         all_done = all_done & lane_status[i].done;
      end
   end

   assign take    = !full_ff && all_done;
   assign is_last = idx_ff == AXIS_W'(NUM_AXES - 1);

   always_comb begin
      full_in = full_ff;
      idx_in  = idx_ff;
      if (take) begin
         full_in = 1'b1;
         idx_in  = '0;
      end else if (full_ff && rsp_ready) begin
         if (is_last) begin
            full_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + AXIS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         full_ff <= full_in;
         idx_ff  <= idx_in;
      end
      if (take) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            buf_ff[i] <= lane_result[i];
         end
      end
   end

   assign rsp_valid             = full_ff;
   assign rsp_word.axis         = idx_ff;
   assign rsp_word.coeff0       = buf_ff[idx_ff].coeff0;
   assign rsp_word.coeff1       = buf_ff[idx_ff].coeff1;
   assign rsp_word.coeff2       = buf_ff[idx_ff].coeff2;
   assign rsp_word.coeff3       = buf_ff[idx_ff].coeff3;
   assign rsp_word.coeff4       = buf_ff[idx_ff].coeff4;
   assign rsp_word.coeff5       = buf_ff[idx_ff].coeff5;
   assign rsp_word.bad_duration = buf_ff[idx_ff].bad;
   assign rsp_word.last         = is_last;

endmodule
`default_nettype wire

// ===== src/min_jerk_quintic_coefficients.sv =====
// Minimum-jerk quintic coefficients, one lane per axis and a merging output stage.
// Segment word: 5 product steps, then per coefficient a load and power x 192 divider
// steps against T, after which the lane results are registered into the output stage.
// Zero duration goes straight to a result flagged bad; start words give no result.
// A new word is taken once every lane has handed its result to the output stage.
// Synchronous reset clears axis state to zero, idles the lanes and empties the output.
`default_nettype none
`include "min_jerk_quintic_coefficients_assert.svh"
module min_jerk_quintic_coefficients import mjq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);

   lane_status_type    lane_status [NUM_AXES];
   lane_result_type    lane_result [NUM_AXES];
   logic signed [31:0] pos_sel [3];
   logic signed [31:0] vel_sel [3];
   logic signed [31:0] acc_sel [3];
   logic               take;
   logic               req_fire;

   assign pos_sel = '{req_word.pos_x, req_word.pos_y, req_word.pos_z};
   assign vel_sel = '{req_word.vel_x, req_word.vel_y, req_word.vel_z};
   assign acc_sel = '{req_word.acc_x, req_word.acc_y, req_word.acc_z};

   always_comb begin
      req_ready = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         req_ready = req_ready & lane_status[i].idle;
      end
   end

   assign req_fire = req_valid && req_ready;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      mjq_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .go     (req_fire),
         .func   (req_word.func),
         .pos    (pos_sel[a]),
         .vel    (vel_sel[a]),
         .acc    (acc_sel[a]),
         .tq     (req_word.duration),
         .take   (take),
         .status (lane_status[a]),
         .result (lane_result[a])
      );
   end

   mjq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_status (lane_status),
      .lane_result (lane_result),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   `MJQ_ASSERT_NEXT(a_busy_after_segment, clock, reset,
      req_fire && req_word.func == FUNC_SEGMENT, !req_ready)
   `MJQ_ASSERT_NEXT(a_empty_after_last, clock, reset,
      rsp_valid && rsp_ready && rsp_word.last, !rsp_valid)
   `MJQ_ASSERT_NOW(a_bad_gives_zero, clock, reset, rsp_valid && rsp_word.bad_duration,
      rsp_word.coeff0 == 64'sd0 && rsp_word.coeff3 == 64'sd0 && rsp_word.coeff5 == 64'sd0)

endmodule
`default_nettype wire

// ===== tb/min_jerk_quintic_coefficients_checker.sv =====
// Checker for the quintic coefficient block: predicts each segment's coefficients and compares.
`timescale 1ns / 1ps
module min_jerk_quintic_coefficients_checker import mjq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_word,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_word,
   output int           fail_count,
   output int           pending_count,
   output int           segment_count,
   output int           saturated_count
);

   logic signed [31:0] start_pos [NUM_AXES];
   logic signed [31:0] start_vel [NUM_AXES];
   logic signed [31:0] start_acc [NUM_AXES];
   rsp_type            coeff_expect_q [$];

   function automatic logic [63:0] quotient_q32(input logic signed [255:0] num,
                                                input int shift, input int power,
                                                input logic [31:0] tq);
      logic         neg;
      logic [255:0] mag;
      logic [255:0] den;
      logic [255:0] q;
      logic [63:0]  r;
      neg = num[255];
      mag = neg ? -num : num;
      mag = mag << shift;
      den = 256'd1;
      for (int i = 0; i < power; i++) den = den * {224'd0, tq};
      q = mag / den;
      if (neg) begin
         if (|q[255:64] || q[63:0] > {1'b1, 63'd0}) r = {1'b1, 63'd0};
         else r = -q[63:0];
      end else begin
         if (|q[255:64] || q[63]) r = {1'b0, {63{1'b1}}};
         else r = q[63:0];
      end
      return r;
   endfunction

   function automatic rsp_type segment_coeffs(input int ax, input logic signed [31:0] tgt,
                                              input logic [31:0] tq);
      rsp_type            r;
      logic signed [255:0] hs, vs, as, tqs;
      logic signed [63:0]  p0, v0, a0;
      r = '0;
      r.axis = ax[AXIS_W-1:0];
      r.last = (ax == NUM_AXES - 1);
      if (tq == 32'd0) begin
         r.bad_duration = 1'b1;
         return r;
      end
      p0 = start_pos[ax];
      v0 = start_vel[ax];
      a0 = start_acc[ax];
      tqs = {224'd0, tq};
      hs = tgt;
      hs = (hs - start_pos[ax]) <<< 48;
      vs = start_vel[ax];
      vs = (vs * tqs) <<< 24;
      as = start_acc[ax];
      as = as * tqs * tqs;
      r.coeff0 = p0 <<< 16;
      r.coeff1 = v0 <<< 16;
      r.coeff2 = a0 <<< 15;
      r.coeff3 = quotient_q32(20 * hs - 12 * vs - 3 * as, 39, 3, tq);
      r.coeff4 = quotient_q32(-30 * hs + 16 * vs + 3 * as, 63, 4, tq);
      r.coeff5 = quotient_q32(12 * hs - 6 * vs - as, 87, 5, tq);
      return r;
   endfunction

   assign pending_count = coeff_expect_q.size();

   always @(posedge clock) begin
      rsp_type e;
      logic signed [31:0] tgt [NUM_AXES];
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            start_pos[a] = '0;
            start_vel[a] = '0;
            start_acc[a] = '0;
         end
         coeff_expect_q.delete();
         fail_count = 0;
         segment_count = 0;
         saturated_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (coeff_expect_q.size() == 0) begin
               $error("result word with no expectation: axis %0d", rsp_word.axis);
               fail_count++;
            end else begin
               e = coeff_expect_q.pop_front();
               if (rsp_word.axis !== e.axis) begin
                  $error("axis: expected %0d got %0d", e.axis, rsp_word.axis); fail_count++;
               end
               if (rsp_word.coeff0 !== e.coeff0) begin
                  $error("coeff0: expected %h got %h", e.coeff0, rsp_word.coeff0); fail_count++;
               end
               if (rsp_word.coeff1 !== e.coeff1) begin
                  $error("coeff1: expected %h got %h", e.coeff1, rsp_word.coeff1); fail_count++;
               end
               if (rsp_word.coeff2 !== e.coeff2) begin
                  $error("coeff2: expected %h got %h", e.coeff2, rsp_word.coeff2); fail_count++;
               end
               if (rsp_word.coeff3 !== e.coeff3) begin
                  $error("coeff3: expected %h got %h", e.coeff3, rsp_word.coeff3); fail_count++;
               end
               if (rsp_word.coeff4 !== e.coeff4) begin
                  $error("coeff4: expected %h got %h", e.coeff4, rsp_word.coeff4); fail_count++;
               end
               if (rsp_word.coeff5 !== e.coeff5) begin
                  $error("coeff5: expected %h got %h", e.coeff5, rsp_word.coeff5); fail_count++;
               end
               if (rsp_word.bad_duration !== e.bad_duration) begin
                  $error("bad_duration: expected %0d got %0d", e.bad_duration,
                         rsp_word.bad_duration);
                  fail_count++;
               end
               if (rsp_word.last !== e.last) begin
                  $error("last: expected %0d got %0d", e.last, rsp_word.last); fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            tgt[0] = req_word.pos_x;
            tgt[1] = req_word.pos_y;
            tgt[2] = req_word.pos_z;
            if (req_word.func == FUNC_START) begin
               start_vel[0] = req_word.vel_x;
               start_vel[1] = req_word.vel_y;
               start_vel[2] = req_word.vel_z;
               start_acc[0] = req_word.acc_x;
               start_acc[1] = req_word.acc_y;
               start_acc[2] = req_word.acc_z;
               for (int a = 0; a < NUM_AXES; a++) start_pos[a] = tgt[a];
            end else begin
               segment_count++;
               for (int a = 0; a < NUM_AXES; a++) begin
                  e = segment_coeffs(a, tgt[a], req_word.duration);
                  if (e.coeff3 == {1'b0, {63{1'b1}}} || e.coeff3 == {1'b1, 63'd0})
                     saturated_count++;
                  coeff_expect_q.push_back(e);
               end
               for (int a = 0; a < NUM_AXES; a++) begin
                  start_pos[a] = tgt[a];
                  start_vel[a] = '0;
                  start_acc[a] = '0;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_min_jerk_quintic_coefficients.sv =====
// Testbench top for the quintic coefficient block: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module tb_min_jerk_quintic_coefficients;
   import mjq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;
   int      fail_count, pending_count, segment_count, saturated_count;
   int      sent_count = 0;
   logic    quiet = 1'b0;
   logic    stall_done = 1'b0;

   min_jerk_quintic_coefficients dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   min_jerk_quintic_coefficients_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count),
      .segment_count(segment_count), .saturated_count(saturated_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #80ms;
      $display("timeout with %0d results pending", pending_count);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_word(input req_type w);
      while (!quiet && $urandom_range(99) < 27) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic req_type start_word(input logic [31:0] p, input logic [31:0] v,
                                          input logic [31:0] a);
      req_type w;
      w = '0;
      w.func = FUNC_START;
      w.pos_x = p; w.pos_y = -p; w.pos_z = p ^ 32'h5555_5555;
      w.vel_x = v; w.vel_y = -v; w.vel_z = ~v;
      w.acc_x = a; w.acc_y = -a; w.acc_z = ~a;
      w.duration = $urandom();
      return w;
   endfunction

   function automatic req_type segment_word(input logic [31:0] p, input logic [31:0] t);
      req_type w;
      w = '0;
      w.func = FUNC_SEGMENT;
      w.pos_x = p; w.pos_y = ~p; w.pos_z = p + 32'h0001_0000;
      w.vel_x = $urandom(); w.vel_y = $urandom(); w.vel_z = $urandom();
      w.acc_x = $urandom(); w.acc_y = $urandom(); w.acc_z = $urandom();
      w.duration = t;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      k;
      w.func = ($urandom_range(99) < 70) ? FUNC_SEGMENT : FUNC_START;
      w.pos_x = $urandom(); w.pos_y = $urandom(); w.pos_z = $urandom();
      w.vel_x = $urandom(); w.vel_y = $urandom(); w.vel_z = $urandom();
      w.acc_x = $urandom(); w.acc_y = $urandom(); w.acc_z = $urandom();
      if ($urandom_range(1)) begin
         w.pos_x = $signed(w.pos_x) >>> $urandom_range(31);
         w.vel_x = $signed(w.vel_x) >>> $urandom_range(31);
         w.acc_x = $signed(w.acc_x) >>> $urandom_range(31);
      end
      k = $urandom_range(99);
      if (k < 5) w.duration = 32'd0;
      else if (k < 15) w.duration = $urandom_range(255);
      else if (k < 60) w.duration = $urandom() >> $urandom_range(31);
      else w.duration = $urandom();
      return w;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         begin
            send_word(segment_word(32'h7fff_ffff, 32'h0100_0000));
            send_word(segment_word(32'h8000_0000, 32'd0));
            send_word(start_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
            send_word(segment_word(32'h8000_0000, 32'd1));
            send_word(start_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            send_word(segment_word(32'h7fff_ffff, 32'hffff_ffff));
            send_word(start_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            send_word(segment_word(32'h0000_0000, 32'd1));
            send_word(start_word(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000));
            send_word(segment_word(32'h0005_0000, 32'h0200_0000));
            send_word(segment_word(32'h0005_0000, 32'h0080_0000));
            send_word(segment_word(32'hfff0_0000, 32'h8000_0000));
            send_word(start_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
            send_word(segment_word(32'h0000_0000, 32'h0000_0001));
            send_word(start_word(32'h1234_5678, 32'hffff_ffff, 32'h0000_0001));
            send_word(segment_word(32'h1234_5678, 32'd0));
            send_word(segment_word(32'hffff_ffff, 32'h00ff_ffff));
            for (int i = 0; i < 355; i++) begin
               quiet = (i >= 150 && i < 220);
               if (i == 250) begin
                  wait (pending_count == 0);
                  @(negedge clock);
               end
               send_word(random_word());
            end
            quiet = 1'b0;
         end
         begin
            while (1) begin
               @(negedge clock);
               if (sent_count == 80 && !stall_done) begin
                  rsp_ready = 1'b0;
                  repeat (9000) @(negedge clock);
                  stall_done = 1'b1;
               end
               rsp_ready = (quiet || $urandom_range(99) >= 27);
               if (sent_count >= 372) rsp_ready = 1'b1;
            end
         end
         begin
            wait (sent_count >= 372);
         end
      join_any
      wait (pending_count == 0);
      repeat (3000) @(posedge clock);
      $display("segments %0d, words sent %0d, saturated c3 results %0d",
               segment_count, sent_count, saturated_count);
      $display("covered start loads, zero durations, tiny and full-range T, long output stall");
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/mjq_pkg.sv
src/mjq_lane.sv
src/mjq_merge.sv
src/min_jerk_quintic_coefficients.sv
tb/min_jerk_quintic_coefficients_checker.sv
tb/tb_min_jerk_quintic_coefficients.sv
